/* src/g7phd_pkg.sv */
// shared types, constants and decode functions for the gsm7 packed hex decoder
// no dependencies
package g7phd_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int MAX_RESULTS = 3;

   localparam logic [6:0] SEPT_LF     = 7'h0a;
   localparam logic [6:0] SEPT_CR     = 7'h0d;
   localparam logic [6:0] SEPT_UNDER  = 7'h11;
   localparam logic [6:0] SEPT_DOLLAR = 7'h02;
   localparam logic [6:0] CHAR_UNDER  = 7'h5f;
   localparam logic [6:0] CHAR_DOLLAR = 7'h24;
   localparam logic [6:0] CHAR_QMARK  = 7'h3f;
   localparam logic [3:0] SEPT_BITS   = 4'd7;
   localparam logic [3:0] BYTE_BITS   = 4'd8;
   localparam logic [3:0] FULL_BITS   = 4'd14;

   typedef struct packed {
      logic [6:0] out_char;
      logic       is_status;
      logic       error;
      logic       last_result;
   } rsp_item_type;

   typedef struct packed {
      logic [1:0]                         count;
      rsp_item_type [MAX_RESULTS-1:0]     items;
   } push_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } hex_digit_type;

   function automatic hex_digit_type hex_decode(input logic [7:0] c);
      hex_digit_type d;
      d.valid = 1'b1;
      d.value = 4'd0;
      case (c) inside
         [8'h30:8'h39]: d.value = c[3:0];
         [8'h41:8'h46],
         [8'h61:8'h66]: d.value = 4'(c[3:0] + 4'd9);
         default:       d.valid = 1'b0;
      endcase
      return d;
   endfunction

   function automatic logic [6:0] map_septet(input logic [6:0] s);
      logic [6:0] r;
      r = CHAR_QMARK;
      case (s) inside
         SEPT_LF, SEPT_CR:                      r = s;
         SEPT_UNDER:                            r = CHAR_UNDER;
         SEPT_DOLLAR:                           r = CHAR_DOLLAR;
         [7'h20:7'h3f], [7'h41:7'h5a],
         [7'h61:7'h7a]:                         r = s;
         default:                               r = CHAR_QMARK;
      endcase
      return r;
   endfunction

endpackage

/* src/g7phd_unpack.sv */
// nibble pairing, septet extraction and mapping for one hex character
// depends on g7phd_pkg
module g7phd_unpack
   import g7phd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] hex_char,
   input  logic       last_char,
   output push_type   push
);

   logic        nibble_pending_ff, nibble_pending_in;
   logic [3:0]  high_nibble_ff, high_nibble_in;
   logic [13:0] bit_accum_ff, bit_accum_in;
   logic [3:0]  bit_count_ff, bit_count_in;
   logic        error_seen_ff, error_seen_in;

   hex_digit_type digit;
   logic [7:0]    byte_val;
   logic [13:0]   acc;
   logic [3:0]    total;
   logic [1:0]    n;

   always_comb begin
      nibble_pending_in = nibble_pending_ff;
      high_nibble_in    = high_nibble_ff;
      bit_accum_in      = bit_accum_ff;
      bit_count_in      = bit_count_ff;
      error_seen_in     = error_seen_ff;
      digit             = hex_decode(hex_char);
      byte_val          = {high_nibble_ff, digit.value};
      acc               = bit_accum_ff | (14'(byte_val) << bit_count_ff[2:0]);
      total             = bit_count_ff + BYTE_BITS;
      n                 = 2'd0;
      push.items        = '0;

      if (!error_seen_ff) begin
         if (!digit.valid) begin
            error_seen_in = 1'b1;
         end else if (!nibble_pending_ff) begin
            high_nibble_in    = digit.value;
            nibble_pending_in = 1'b1;
         end else begin
            nibble_pending_in = 1'b0;
            push.items[0].out_char = map_septet(acc[6:0]);
            n = 2'd1;
            if (total == FULL_BITS) begin
               push.items[1].out_char = map_septet(acc[13:7]);
               n            = 2'd2;
               bit_accum_in = '0;
               bit_count_in = '0;
            end else begin
               bit_accum_in = acc >> 7;
               bit_count_in = total - SEPT_BITS;
            end
         end
      end

      if (last_char) begin
         push.items[n].out_char    = '0;
         push.items[n].is_status   = 1'b1;
         push.items[n].error       = error_seen_in | nibble_pending_in;
         push.items[n].last_result = 1'b1;
         n                 = n + 2'd1;
         nibble_pending_in = 1'b0;
         high_nibble_in    = '0;
         bit_accum_in      = '0;
         bit_count_in      = '0;
         error_seen_in     = 1'b0;
      end

      push.count = accept ? n : 2'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nibble_pending_ff <= 1'b0;
         high_nibble_ff    <= '0;
         bit_accum_ff      <= '0;
         bit_count_ff      <= '0;
         error_seen_ff     <= 1'b0;
      end else if (accept) begin
         nibble_pending_ff <= nibble_pending_in;
         high_nibble_ff    <= high_nibble_in;
         bit_accum_ff      <= bit_accum_in;
         bit_count_ff      <= bit_count_in;
         error_seen_ff     <= error_seen_in;
      end
   end

endmodule

/* src/g7phd_queue.sv */
// four-entry shifting result queue, takes up to three results per cycle
// depends on g7phd_pkg
module g7phd_queue
   import g7phd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  push_type     push,
   output logic         room,
   output logic         out_valid,
   input  logic         out_ready,
   output rsp_item_type out_item
);

   rsp_item_type [QUEUE_DEPTH-1:0] q_ff, q_in;
   logic [2:0] count_ff, count_in;
   logic [2:0] base;
   logic [2:0] off;
   logic       pop;

   assign out_valid = (count_ff != 3'd0);
   assign pop       = out_valid & out_ready;
   assign base      = count_ff - {2'b00, pop};
   assign room      = (base <= 3'(QUEUE_DEPTH - MAX_RESULTS));
   assign out_item  = q_ff[0];

   always_comb begin
      off = '0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (pop && i < QUEUE_DEPTH - 1) begin
            q_in[i] = q_ff[i+1];
         end else begin
            q_in[i] = q_ff[i];
         end
         off = 3'(i) - base;
         if (3'(i) >= base && off < {1'b0, push.count}) begin
            q_in[i] = push.items[off[1:0]];
         end
      end
      count_in = base + {1'b0, push.count};
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

/* src/gsm7_packed_hex_decoder.sv */
// top level of the gsm7 packed hex decoder: unpacker feeding a result queue
// depends on g7phd_pkg, g7phd_unpack, g7phd_queue
//
//   channel | direction | tdata               | tuser                    | tlast
//   req     | in        | [7:0] hex_char      | -                        | last_char
//   rsp     | out       | [6:0] out_char      | [0] is_status, [1] error | last_result
//
// one hex character is taken per cycle while req_tready is high; its zero to three
// results enter the four-entry queue at once and leave one per cycle from a register
// req_tready is high while the queue, after this cycle's pop, holds at most one result
// a character that yields one result or fewer sustains one transaction per cycle
// synchronous reset clears the decoder state and empties the queue
module gsm7_packed_hex_decoder
   import g7phd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] hex_char
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [6:0] out_char, [7] zero
   output logic [1:0] rsp_tuser,   // [0] is_status, [1] error
   output logic       rsp_tlast
);

   push_type     push;
   rsp_item_type head;
   logic         room;
   logic         accept;

   assign req_tready = room;
   assign accept     = req_tvalid & room;

   g7phd_unpack u_unpack (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .hex_char  (req_tdata),
      .last_char (req_tlast),
      .push      (push)
   );

   g7phd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (head)
   );

   assign rsp_tdata = {1'b0, head.out_char};
   assign rsp_tuser = {head.error, head.is_status};
   assign rsp_tlast = head.last_result;

endmodule

/* sim/gsm7_packed_hex_decoder_test.sv */
// testbench for gsm7_packed_hex_decoder: hex payloads in, decoded septets and status out
// depends on g7phd_pkg and the rtl under src; self-checking against an in-bench decoder
// directed payloads first, then random payloads with stalls on both sides

module gsm7_packed_hex_decoder_test;
   import g7phd_pkg::*;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;   // [7:0] hex_char
   logic       req_tlast;
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;   // [6:0] out_char, [7] zero
   logic [1:0] rsp_tuser;   // [0] is_status, [1] error
   logic       rsp_tlast;

   gsm7_packed_hex_decoder u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // decoder state mirrored in the bench
   logic        dec_pending;
   logic [3:0]  dec_high;
   logic [13:0] dec_accum;
   logic [3:0]  dec_count;
   logic        dec_error;

   rsp_item_type decoded_q[$];
   logic [7:0]   payload_q[$];
   int           mismatch_count = 0;
   bit           idle_on;
   bit           hold_req;
   int           hold_cycles;

   function automatic logic [6:0] septet_to_char(input logic [6:0] s);
      if (s == SEPT_LF || s == SEPT_CR) return s;
      if (s == SEPT_UNDER) return CHAR_UNDER;
      if (s == SEPT_DOLLAR) return CHAR_DOLLAR;
      if ((s >= 7'h20 && s <= 7'h3f) || (s >= 7'h41 && s <= 7'h5a) ||
          (s >= 7'h61 && s <= 7'h7a)) return s;
      return CHAR_QMARK;
   endfunction

   function automatic void push_decoded(input logic [6:0] ch, input logic st,
                                        input logic er);
      rsp_item_type r;
      r.out_char    = ch;
      r.is_status   = st;
      r.error       = er;
      r.last_result = st;
      decoded_q.insert(decoded_q.size(), r);
   endfunction

   function automatic void decode_char(input logic [7:0] c, input logic last);
      logic       ok;
      logic [3:0] v;
      logic [7:0] data_byte;
      ok = 1'b1;
      v = 4'd0;
      if (c >= "0" && c <= "9") v = 4'(c - 8'h30);
      else if (c >= "A" && c <= "F") v = 4'(c - 8'h37);
      else if (c >= "a" && c <= "f") v = 4'(c - 8'h57);
      else ok = 1'b0;
      if (!dec_error) begin
         if (!ok) begin
            dec_error = 1'b1;
         end else if (!dec_pending) begin
            dec_high = v;
            dec_pending = 1'b1;
         end else begin
            data_byte = {dec_high, v};
            dec_pending = 1'b0;
            dec_accum = 14'(dec_accum | (16'(data_byte) << dec_count));
            dec_count = dec_count + BYTE_BITS;
            while (dec_count >= SEPT_BITS) begin
               push_decoded(septet_to_char(dec_accum[6:0]), 1'b0, 1'b0);
               dec_accum = dec_accum >> 7;
               dec_count = dec_count - SEPT_BITS;
            end
         end
      end
      if (last) begin
         if (dec_pending) dec_error = 1'b1;
         push_decoded(7'd0, 1'b1, dec_error);
         dec_pending = 1'b0;
         dec_high = 4'd0;
         dec_accum = 14'd0;
         dec_count = 4'd0;
         dec_error = 1'b0;
      end
   endfunction

   // payload text builders
   function automatic logic [7:0] hex_text(input logic [3:0] v);
      if (v < 4'd10) return 8'h30 + 8'(v);
      return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(v - 4'd10);
   endfunction

   function automatic void append_char(input logic [7:0] c);
      payload_q.insert(payload_q.size(), c);
   endfunction

   function automatic void add_byte(input logic [7:0] b);
      append_char(hex_text(b[7:4]));
      append_char(hex_text(b[3:0]));
   endfunction

   function automatic void add_text(input string s);
      for (int i = 0; i < s.len(); i++) append_char(s[i]);
   endfunction

   function automatic void add_septets(input int n);
      logic [15:0] acc;
      int          cnt;
      acc = 16'd0;
      cnt = 0;
      for (int i = 0; i < n; i++) begin
         acc = acc | (16'($urandom_range(0, 127)) << cnt);
         cnt = cnt + 7;
         while (cnt >= 8) begin
            add_byte(acc[7:0]);
            acc = acc >> 8;
            cnt = cnt - 8;
         end
      end
      if (cnt > 0) add_byte(acc[7:0]);
   endfunction

   task automatic send_char(input logic [7:0] c, input logic last);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      decode_char(c, last);
      @(negedge clock);
   endtask

   task automatic send_payload();
      int n;
      n = payload_q.size();
      for (int i = 0; i < n; i++) send_char(payload_q[i], i == n - 1);
      payload_q.delete();
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (decoded_q.size() != 0);
      @(negedge clock);
   endtask

   task automatic send_random_payloads(input int n_chars);
      int sent;
      int kind;
      int pos;
      sent = 0;
      while (sent < n_chars) begin
         kind = $urandom_range(0, 9);
         if (kind == 9) repeat ($urandom_range(1, 8))
            append_char(8'($urandom_range(0, 255)));
         else
            add_septets($urandom_range(1, 12));
         // corrupted digit
         if (kind == 7) begin
            pos = $urandom_range(0, payload_q.size() - 1);
            payload_q[pos] = 8'($urandom_range(0, 255));
         end
         // odd length
         if (kind == 8) void'(payload_q.pop_back());
         sent += payload_q.size();
         send_payload();
      end
   endtask

   task automatic test_directed();
      logic [7:0] bad_chars [6] = '{8'h2f, 8'h3a, 8'h40, 8'h60, 8'h67, 8'hff};
      add_text("09AFaf");
      send_payload();
      // lf, cr, underscore, dollar septets
      add_byte(8'h8a);
      add_byte(8'h46);
      add_byte(8'h44);
      add_byte(8'h00);
      send_payload();
      // bad digit, rest of payload ignored
      add_text("1");
      append_char(8'h47);
      add_text("23");
      send_payload();
      add_text("5");
      send_payload();
      add_text("ab");
      append_char(8'h00);
      send_payload();
      foreach (bad_chars[i]) begin
         append_char(bad_chars[i]);
         send_payload();
      end
      wait_drained();
   endtask

   task automatic test_random_traffic();
      send_random_payloads(300);
      wait_drained();
   endtask

   task automatic test_output_hold();
      hold_cycles = 80;
      hold_req = 1'b1;
      send_random_payloads(60);
      wait_drained();
   endtask

   task automatic test_full_rate();
      idle_on = 1'b0;
      send_random_payloads(90);
      wait_drained();
   endtask

   // result sink
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            rsp_tready <= 1'b0;
            repeat (hold_cycles) @(negedge clock);
            hold_req = 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      rsp_item_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (decoded_q.size() == 0) begin
            $error("unexpected transaction: out_char %h tuser %b tlast %b",
                   rsp_tdata[6:0], rsp_tuser, rsp_tlast);
            mismatch_count++;
         end else begin
            e = decoded_q.pop_front();
            if (rsp_tdata[6:0] !== e.out_char) begin
               $error("out_char expected %h actual %h", e.out_char, rsp_tdata[6:0]);
               mismatch_count++;
            end
            if (rsp_tuser[0] !== e.is_status) begin
               $error("is_status expected %b actual %b", e.is_status, rsp_tuser[0]);
               mismatch_count++;
            end
            if (rsp_tuser[1] !== e.error) begin
               $error("error expected %b actual %b", e.error, rsp_tuser[1]);
               mismatch_count++;
            end
            if (rsp_tlast !== e.last_result) begin
               $error("last_result expected %b actual %b", e.last_result, rsp_tlast);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      #4_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = 8'd0;
      req_tlast   = 1'b0;
      idle_on     = 1'b1;
      hold_req    = 1'b0;
      hold_cycles = 0;
      dec_pending = 1'b0;
      dec_high    = 4'd0;
      dec_accum   = 14'd0;
      dec_count   = 4'd0;
      dec_error   = 1'b0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_traffic();
      test_output_hold();
      test_full_rate();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
